// File: rtl/pidc_pkg.sv
// Shared types, constants and codes for the clamped PID controller.
package pidc_pkg;

    localparam int SUM_WIDTH  = 48;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 24;
    localparam int FRAC_SHIFT = 16;
    localparam int NUM_W      = DATA_W + FRAC_SHIFT;
    localparam int SUM_LO_W   = SUM_WIDTH / 2;
    localparam int SUM_HI_W   = SUM_WIDTH - SUM_LO_W;
    localparam int OPND_W     = DATA_W + 1;
    localparam int PROD_W     = DATA_W + OPND_W;
    localparam int ACC_W      = SUM_WIDTH + DATA_W + 2;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 3;

    typedef logic signed [DATA_W-1:0]    t_data;
    typedef logic signed [DATA_W:0]      t_diff;
    typedef logic signed [OPND_W-1:0]    t_opnd;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic signed [SUM_WIDTH-1:0] t_sum;
    typedef logic signed [SUM_WIDTH:0]   t_sum_ext;
    typedef logic [STEP_W-1:0]           t_step;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;

    localparam t_data DATA_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_data PREV_RESET = t_data'(409600000);
    localparam t_sum  SUM_MAX    = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam t_sum  SUM_MIN    = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    localparam t_cfg_idx REG_PGAIN = t_cfg_idx'(0);
    localparam t_cfg_idx REG_IGAIN = t_cfg_idx'(1);
    localparam t_cfg_idx REG_DGAIN = t_cfg_idx'(2);
    localparam t_cfg_idx REG_OMAX  = t_cfg_idx'(3);
    localparam t_cfg_idx REG_OMIN  = t_cfg_idx'(4);

    localparam t_step MUL_P     = t_step'(0);
    localparam t_step MUL_I_LO  = t_step'(1);
    localparam t_step MUL_I_HI  = t_step'(2);
    localparam t_step MUL_D     = t_step'(3);
    localparam t_step MUL_DRAIN = t_step'(4);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN,
        S_CLAMP
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
        logic hi;
    } t_mac_ctl;

endpackage

// File: rtl/pid_controller_clamped.sv
// Top level of the fixed-point PID controller with output clamp.
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes the three
//   Q16.16 gains and the Q20.12 output limits; it is always ready. The user must write
//   it only while the block is idle (not enforced). Indexes beyond the list are ignored.
//   Input channel (i_in_valid/o_in_ready) takes one error sample and time step per
//   transaction; o_in_ready is high only while the sequencer is idle.
//   Output channel (o_out_valid/i_out_ready) returns the clamped control value and
//   the clamp flag, one transaction per input.
//   The sequencer stays busy from an input transaction until its result is loaded:
//   the 48-step restoring divider for the derivative runs unless time_step is zero,
//   then the four products share one multiplier. No new input is taken before the
//   previous result has been loaded into the output register.
//   The result sits in an output register, so a new input is taken while it waits.
//   If the receiver stalls and that register is still full when the next result is
//   ready, the sequencer holds until it drains.
//   Reset restores the register defaults, clears the error sum and loads the previous
//   error with 100000.0; no output is pending after reset.
module pid_controller_clamped (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [pidc_pkg::DATA_W-1:0] i_error_sample,
    input  logic [pidc_pkg::DT_W-1:0]      i_time_step,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [pidc_pkg::DATA_W-1:0] o_control_out,
    output logic                           o_clamped
);

    pidc_pkg::t_state   r_state, n_state;
    pidc_pkg::t_data    r_pgain, r_igain, r_dgain, r_omax, r_omin;
    pidc_pkg::t_data    r_prev, r_deriv, r_total, r_ctl;
    pidc_pkg::t_sum     r_sum;
    pidc_pkg::t_step    r_step;
    logic               r_neg, r_dt_zero, r_out_valid, r_clamped;

    logic                       w_accept, w_cfg_we, w_div_start, w_div_done, w_load;
    logic [pidc_pkg::NUM_W-1:0] w_quot, w_num;
    pidc_pkg::t_diff            w_diff, w_mag;
    pidc_pkg::t_sum_ext         w_sum_ext;
    pidc_pkg::t_sum             w_sum_sat;
    pidc_pkg::t_data            w_deriv, w_total, w_lo, w_ctl, w_gain;
    pidc_pkg::t_opnd            w_opnd;
    pidc_pkg::t_acc             w_acc;
    pidc_pkg::t_mac_ctl         w_mac_ctl;
    logic [pidc_pkg::ACC_W-pidc_pkg::FRAC_SHIFT-pidc_pkg::DATA_W:0] w_acc_hi;

    assign o_cfg_ready   = 1'b1;
    assign w_cfg_we      = i_cfg_valid;
    assign w_accept      = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_ctl;
    assign o_clamped     = r_clamped;

    // derivative numerator magnitude, Q.28
    assign w_diff = pidc_pkg::t_diff'(i_error_sample) - pidc_pkg::t_diff'(r_prev);
    assign w_mag  = w_diff[pidc_pkg::DATA_W] ? pidc_pkg::t_diff'(-w_diff) : w_diff;
    assign w_num  = {w_mag[pidc_pkg::DATA_W-1:0], {pidc_pkg::FRAC_SHIFT{1'b0}}};

    assign w_sum_ext = pidc_pkg::t_sum_ext'(r_sum) + pidc_pkg::t_sum_ext'(i_error_sample);

    always_comb begin
        if (w_sum_ext[pidc_pkg::SUM_WIDTH] != w_sum_ext[pidc_pkg::SUM_WIDTH-1]) begin
            w_sum_sat = w_sum_ext[pidc_pkg::SUM_WIDTH] ? pidc_pkg::SUM_MIN : pidc_pkg::SUM_MAX;
        end else begin
            w_sum_sat = w_sum_ext[pidc_pkg::SUM_WIDTH-1:0];
        end
    end

    always_comb begin
        if (r_dt_zero) begin
            w_deriv = '0;
        end else if (r_neg) begin
            if ((|w_quot[pidc_pkg::NUM_W-1:pidc_pkg::DATA_W]) ||
                (w_quot[pidc_pkg::DATA_W-1] && (|w_quot[pidc_pkg::DATA_W-2:0]))) begin
                w_deriv = pidc_pkg::DATA_MIN;
            end else begin
                w_deriv = pidc_pkg::t_data'(-w_quot[pidc_pkg::DATA_W-1:0]);
            end
        end else if (|w_quot[pidc_pkg::NUM_W-1:pidc_pkg::DATA_W-1]) begin
            w_deriv = pidc_pkg::DATA_MAX;
        end else begin
            w_deriv = pidc_pkg::t_data'(w_quot[pidc_pkg::DATA_W-1:0]);
        end
    end

    // floor shift by 16, then saturate to 32 bits
    assign w_acc_hi = w_acc[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_SHIFT+pidc_pkg::DATA_W-1];

    always_comb begin
        if ((&w_acc_hi) || !(|w_acc_hi)) begin
            w_total = pidc_pkg::t_data'(
                w_acc[pidc_pkg::FRAC_SHIFT+pidc_pkg::DATA_W-1:pidc_pkg::FRAC_SHIFT]);
        end else begin
            w_total = w_acc[pidc_pkg::ACC_W-1] ? pidc_pkg::DATA_MIN : pidc_pkg::DATA_MAX;
        end
    end

    assign w_lo  = (r_total < r_omin) ? r_omin : r_total;
    assign w_ctl = (w_lo > r_omax) ? r_omax : w_lo;

    always_comb begin
        case (r_step)
            pidc_pkg::MUL_P: begin
                w_gain = r_pgain;
                w_opnd = pidc_pkg::t_opnd'(r_prev);
            end
            pidc_pkg::MUL_I_LO: begin
                w_gain = r_igain;
                w_opnd = pidc_pkg::t_opnd'({1'b0, r_sum[pidc_pkg::SUM_LO_W-1:0]});
            end
            pidc_pkg::MUL_I_HI: begin
                w_gain = r_igain;
                w_opnd = pidc_pkg::t_opnd'(
                    signed'(r_sum[pidc_pkg::SUM_WIDTH-1:pidc_pkg::SUM_LO_W]));
            end
            pidc_pkg::MUL_D: begin
                w_gain = r_dgain;
                w_opnd = pidc_pkg::t_opnd'(r_deriv);
            end
            default: begin
                w_gain = '0;
                w_opnd = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_mac_ctl   = '0;
        w_load      = 1'b0;
        unique case (r_state)
            pidc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state     = pidc_pkg::S_DIV;
                    w_div_start = (i_time_step != '0);
                end
            end
            pidc_pkg::S_DIV: begin
                w_mac_ctl.clr = 1'b1;
                if (r_dt_zero || w_div_done) begin
                    n_state = pidc_pkg::S_MUL;
                end
            end
            pidc_pkg::S_MUL: begin
                w_mac_ctl.vld = (r_step != pidc_pkg::MUL_DRAIN);
                w_mac_ctl.hi  = (r_step == pidc_pkg::MUL_I_HI);
                if (r_step == pidc_pkg::MUL_DRAIN) begin
                    n_state = pidc_pkg::S_FIN;
                end
            end
            pidc_pkg::S_FIN: begin
                n_state = pidc_pkg::S_CLAMP;
            end
            pidc_pkg::S_CLAMP: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = pidc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidc_pkg::S_IDLE;
            r_pgain     <= '0;
            r_igain     <= '0;
            r_dgain     <= '0;
            r_omax      <= pidc_pkg::DATA_MAX;
            r_omin      <= pidc_pkg::DATA_MIN;
            r_prev      <= pidc_pkg::PREV_RESET;
            r_sum       <= '0;
            r_step      <= pidc_pkg::MUL_P;
            r_dt_zero   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    pidc_pkg::REG_PGAIN: r_pgain <= i_cfg_data;
                    pidc_pkg::REG_IGAIN: r_igain <= i_cfg_data;
                    pidc_pkg::REG_DGAIN: r_dgain <= i_cfg_data;
                    pidc_pkg::REG_OMAX:  r_omax  <= i_cfg_data;
                    pidc_pkg::REG_OMIN:  r_omin  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_prev    <= i_error_sample;
                r_sum     <= w_sum_sat;
                r_neg     <= w_diff[pidc_pkg::DATA_W];
                r_dt_zero <= (i_time_step == '0);
            end
            if (r_state == pidc_pkg::S_DIV) begin
                r_deriv <= w_deriv;
                r_step  <= pidc_pkg::MUL_P;
            end
            if (r_state == pidc_pkg::S_MUL) begin
                r_step <= r_step + pidc_pkg::t_step'(1);
            end
            if (r_state == pidc_pkg::S_FIN) begin
                r_total <= w_total;
            end
            if (w_load) begin
                r_ctl       <= w_ctl;
                r_clamped   <= (w_ctl != r_total);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (i_time_step),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    pidc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_gain  (w_gain),
        .i_opnd  (w_opnd),
        .o_acc   (w_acc)
    );

endmodule

// File: rtl/pidc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pidc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pidc_pkg::NUM_W-1:0] i_num,
    input  logic [pidc_pkg::DT_W-1:0]  i_den,
    output logic                       o_done,
    output logic [pidc_pkg::NUM_W-1:0] o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [pidc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pidc_pkg::DT_W-1:0]      r_rem;
    logic [pidc_pkg::DT_W-1:0]      r_den;
    logic [pidc_pkg::NUM_W-1:0]     r_quot;
    logic [pidc_pkg::DT_W:0]        w_trial;
    logic [pidc_pkg::DT_W:0]        w_diff;
    logic                           w_ge;

    assign w_trial = {r_rem, r_quot[pidc_pkg::NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quot <= i_num;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[pidc_pkg::DT_W-1:0] : w_trial[pidc_pkg::DT_W-1:0];
                r_quot <= {r_quot[pidc_pkg::NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt + pidc_pkg::DIV_CNT_W'(1);
                if (r_cnt == pidc_pkg::DIV_CNT_W'(pidc_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/pidc_mac.sv
// Shared signed multiplier with registered product and wide accumulator.
module pidc_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidc_pkg::t_mac_ctl i_ctl,
    input  pidc_pkg::t_data    i_gain,
    input  pidc_pkg::t_opnd    i_opnd,
    output pidc_pkg::t_acc     o_acc
);

    pidc_pkg::t_prod r_prod;
    logic            r_prod_vld;
    logic            r_prod_hi;
    pidc_pkg::t_acc  r_acc;
    pidc_pkg::t_acc  w_ext;
    pidc_pkg::t_acc  w_addend;

    assign w_ext    = pidc_pkg::t_acc'(r_prod);
    assign w_addend = r_prod_hi ? pidc_pkg::t_acc'(w_ext << pidc_pkg::SUM_LO_W) : w_ext;
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_prod_hi  <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
            r_prod_hi  <= i_ctl.hi;
            r_prod     <= i_gain * i_opnd;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + w_addend;
            end
        end
    end

endmodule

// File: rtl/pidc_chk.sv
// Port-level checker for the PID controller, bound to the top level.
module pidc_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [pidc_pkg::DATA_W-1:0] o_control_out,
    input logic                               o_clamped
);

    // busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a transaction");

    // a result never appears right after an input transaction
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##1 !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared too soon after input");

    // a new result coincides with the sequencer going idle
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while sequencer busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_control_out) && $stable(o_clamped)))
        else $error("stalled output transaction changed");

endmodule

bind pid_controller_clamped pidc_chk u_pidc_chk (.*);

// File: test/pid_controller_clamped_tb.sv
// Self-checking testbench for pid_controller_clamped against a local predictor.
`timescale 1ns / 1ps

module pid_controller_clamped_tb;

    localparam longint unsigned    CYCLE_LIMIT     = 2_000_000;
    localparam int                 PHASES          = 10;
    localparam int                 ITEMS_PER_PHASE = 192;
    localparam pidc_pkg::t_data    ONE_Q16         = pidc_pkg::t_data'(32'h0001_0000);
    localparam pidc_pkg::t_cfg_idx REG_SPARE_LO    = pidc_pkg::t_cfg_idx'(5);
    localparam pidc_pkg::t_cfg_idx REG_SPARE_HI    = pidc_pkg::t_cfg_idx'(7);

    typedef struct packed {
        pidc_pkg::t_data ctl;
        logic            clamped;
    } t_control;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    pidc_pkg::t_cfg_idx            i_cfg_index = '0;
    logic [pidc_pkg::DATA_W-1:0]   i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    pidc_pkg::t_data               i_error_sample = '0;
    logic [pidc_pkg::DT_W-1:0]     i_time_step = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    pidc_pkg::t_data               o_control_out;
    logic                          o_clamped;

    // predictor copy of registers and state
    pidc_pkg::t_data gain_p, gain_i, gain_d, ctl_max, ctl_min;
    pidc_pkg::t_data prev_err;
    pidc_pkg::t_sum  err_sum;

    t_control        pending_controls[$];
    int              err_count = 0;
    int              burst_left = 0;
    int              ready_run = 0;
    int              stall_run = 0;
    longint unsigned cycle_count = 0;

    pid_controller_clamped u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_error_sample (i_error_sample),
        .i_time_step    (i_time_step),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_control_out  (o_control_out),
        .o_clamped      (o_clamped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_controls.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_control compute_control(input pidc_pkg::t_data err,
                                                 input logic [pidc_pkg::DT_W-1:0] dt);
        longint              num;
        longint              quo;
        longint              sum_wide;
        pidc_pkg::t_data     deriv;
        pidc_pkg::t_data     total;
        logic signed [127:0] acc;
        t_control            res;
        deriv = '0;
        if (dt != '0) begin
            num = (longint'(err) - longint'(prev_err)) * 65536;
            quo = num / longint'(dt);
            if (quo > longint'(pidc_pkg::DATA_MAX)) deriv = pidc_pkg::DATA_MAX;
            else if (quo < longint'(pidc_pkg::DATA_MIN)) deriv = pidc_pkg::DATA_MIN;
            else deriv = pidc_pkg::t_data'(quo);
        end
        sum_wide = longint'(err_sum) + longint'(err);
        if (sum_wide > longint'(pidc_pkg::SUM_MAX)) err_sum = pidc_pkg::SUM_MAX;
        else if (sum_wide < longint'(pidc_pkg::SUM_MIN)) err_sum = pidc_pkg::SUM_MIN;
        else err_sum = pidc_pkg::t_sum'(sum_wide);
        prev_err = err;

        acc = gain_p * err + gain_i * err_sum + gain_d * deriv;
        acc = acc >>> pidc_pkg::FRAC_SHIFT;
        if (acc > pidc_pkg::DATA_MAX) total = pidc_pkg::DATA_MAX;
        else if (acc < pidc_pkg::DATA_MIN) total = pidc_pkg::DATA_MIN;
        else total = pidc_pkg::t_data'(acc);

        res.ctl = total;
        if (res.ctl < ctl_min) res.ctl = ctl_min;
        if (res.ctl > ctl_max) res.ctl = ctl_max;
        res.clamped = (res.ctl != total);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 50)
            $display("%0t mismatch, %s: got 0x%08h expected 0x%08h", $time, what, got, want);
    endtask

    // result check and receiver stall pattern
    always @(posedge i_clk) begin : check_results
        t_control want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_controls.size() == 0) begin
                report_mismatch("unexpected transaction", o_control_out, '0);
            end else begin
                want = pending_controls.pop_front();
                if (o_control_out !== want.ctl)
                    report_mismatch("control_out", o_control_out, want.ctl);
                if (o_clamped !== want.clamped)
                    report_mismatch("clamped", 32'(o_clamped), 32'(want.clamped));
            end
        end
        if (ready_run == 0 && stall_run == 0) begin
            ready_run = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: stall_run = 0;
                1: stall_run = $urandom_range(1, 4);
                default: stall_run = $urandom_range(5, 90);
            endcase
        end
        if (stall_run > 0) begin
            stall_run--;
            i_out_ready <= 1'b0;
        end else begin
            ready_run--;
            i_out_ready <= 1'b1;
        end
    end

    // leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_register(input pidc_pkg::t_cfg_idx idx, input pidc_pkg::t_data val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pidc_pkg::REG_PGAIN: gain_p  = val;
            pidc_pkg::REG_IGAIN: gain_i  = val;
            pidc_pkg::REG_DGAIN: gain_d  = val;
            pidc_pkg::REG_OMAX:  ctl_max = val;
            pidc_pkg::REG_OMIN:  ctl_min = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_controls.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input pidc_pkg::t_data kp, input pidc_pkg::t_data ki,
                                 input pidc_pkg::t_data kd, input pidc_pkg::t_data hi,
                                 input pidc_pkg::t_data lo);
        wait_drained();
        write_register(pidc_pkg::REG_PGAIN, kp);
        write_register(pidc_pkg::REG_IGAIN, ki);
        write_register(pidc_pkg::REG_DGAIN, kd);
        write_register(pidc_pkg::REG_OMAX, hi);
        write_register(pidc_pkg::REG_OMIN, lo);
        if ($urandom_range(0, 3) == 0)
            write_register(pidc_pkg::t_cfg_idx'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                           pidc_pkg::t_data'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input pidc_pkg::t_data err,
                               input logic [pidc_pkg::DT_W-1:0] dt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_error_sample <= err;
        i_time_step    <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_controls.push_back(compute_control(err, dt));
    endtask

    function automatic pidc_pkg::t_data pick_error();
        case ($urandom_range(0, 19))
            0: return pidc_pkg::DATA_MAX;
            1: return pidc_pkg::DATA_MIN;
            2, 3: return pidc_pkg::t_data'($urandom);
            14, 15, 16:
                return prev_err + pidc_pkg::t_data'(int'($urandom_range(0, 2048)) - 1024);
            17, 18, 19:
                return pidc_pkg::t_data'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
            default:
                return pidc_pkg::t_data'(int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000);
        endcase
    endfunction

    function automatic logic [pidc_pkg::DT_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2: return pidc_pkg::DT_W'(1);
            3: return '1;
            4, 5: return pidc_pkg::DT_W'($urandom_range(1, 255));
            6, 7: return pidc_pkg::DT_W'($urandom_range(24'h000100, 24'h040000));
            default: return pidc_pkg::DT_W'($urandom);
        endcase
    endfunction

    function automatic pidc_pkg::t_data pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ($urandom_range(0, 1) != 0) ? pidc_pkg::DATA_MAX : pidc_pkg::DATA_MIN;
            2: return pidc_pkg::t_data'($urandom);
            3, 4, 5:
                return pidc_pkg::t_data'(int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000);
            default:
                return pidc_pkg::t_data'(int'($urandom_range(0, 32'h2000)) - 32'h1000);
        endcase
    endfunction

    // P and I at reset value zero; only D set, so the first output shows the
    // reset value of the previous error
    task automatic test_reset_state();
        wait_drained();
        write_register(pidc_pkg::REG_DGAIN, ONE_Q16);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_sample('0, pidc_pkg::DT_W'(24'h01_0000));
    endtask

    task automatic test_field_extremes();
        load_settings(ONE_Q16, '0, ONE_Q16, pidc_pkg::DATA_MAX, pidc_pkg::DATA_MIN);
        send_sample(pidc_pkg::DATA_MAX, '0);
        send_sample(pidc_pkg::DATA_MIN, pidc_pkg::DT_W'(1));
        send_sample(pidc_pkg::DATA_MAX, pidc_pkg::DT_W'(1));
        send_sample(pidc_pkg::DATA_MAX, '1);
        send_sample(pidc_pkg::t_data'(-1), '1);
        send_sample(pidc_pkg::t_data'(1), pidc_pkg::DT_W'(1));
        send_sample('0, '0);
    endtask

    task automatic test_gain_extremes();
        load_settings(pidc_pkg::DATA_MAX, pidc_pkg::DATA_MAX, pidc_pkg::DATA_MIN,
                      pidc_pkg::DATA_MAX, pidc_pkg::DATA_MIN);
        send_sample(pidc_pkg::DATA_MAX, pidc_pkg::DT_W'(1));
        send_sample(pidc_pkg::DATA_MIN, pidc_pkg::DT_W'(1));
        send_sample(pidc_pkg::DATA_MIN, '0);
        send_sample(pidc_pkg::t_data'(12345), pidc_pkg::DT_W'(77));
    endtask

    task automatic test_output_clamp();
        load_settings(ONE_Q16, '0, '0, pidc_pkg::t_data'(40960), pidc_pkg::t_data'(-40960));
        send_sample(pidc_pkg::t_data'(50000), pidc_pkg::DT_W'(4096));
        send_sample(pidc_pkg::t_data'(-50000), '0);
        send_sample(pidc_pkg::t_data'(40960), pidc_pkg::DT_W'(1));
        send_sample(pidc_pkg::t_data'(-40960), '1);
        send_sample(pidc_pkg::t_data'(100), pidc_pkg::DT_W'(300));
    endtask

    // output_min above output_max: result is always output_max
    task automatic test_crossed_limits();
        load_settings(ONE_Q16, '0, '0, pidc_pkg::t_data'(-4096), pidc_pkg::t_data'(4096));
        send_sample('0, '0);
        send_sample(pidc_pkg::t_data'(8192), pidc_pkg::DT_W'(16));
        send_sample(pidc_pkg::t_data'(-8192), '0);
    endtask

    task automatic test_spare_index();
        wait_drained();
        for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++)
            write_register(pidc_pkg::t_cfg_idx'(k), pidc_pkg::t_data'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_sample(pidc_pkg::t_data'(-20000), pidc_pkg::DT_W'(512));
    endtask

    task automatic test_random_phases();
        pidc_pkg::t_data a, b;
        for (int ph = 0; ph < PHASES; ph++) begin
            a = pidc_pkg::t_data'($urandom);
            b = pidc_pkg::t_data'($urandom);
            case ($urandom_range(0, 4))
                0: load_settings(pick_gain(), pick_gain(), pick_gain(),
                                 pidc_pkg::DATA_MAX, pidc_pkg::DATA_MIN);
                1, 2: load_settings(pick_gain(), pick_gain(), pick_gain(),
                                    (a > b) ? a : b, (a > b) ? b : a);
                3: begin
                    a = pidc_pkg::t_data'(int'($urandom_range(0, 32'h20_0000)) - 32'h10_0000);
                    b = pidc_pkg::t_data'($urandom_range(0, 32'h4_0000));
                    load_settings(pick_gain(), pick_gain(), pick_gain(), a + b, a - b);
                end
                default: load_settings(pick_gain(), pick_gain(), pick_gain(),
                                       (a > b) ? b : a, (a > b) ? a : b);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2 && ph % 3 == 1) wait_drained();
                send_sample(pick_error(), pick_step());
            end
        end
    endtask

    initial begin
        gain_p   = '0;
        gain_i   = '0;
        gain_d   = '0;
        ctl_max  = pidc_pkg::DATA_MAX;
        ctl_min  = pidc_pkg::DATA_MIN;
        prev_err = pidc_pkg::PREV_RESET;
        err_sum  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_gain_extremes();
        test_output_clamp();
        test_crossed_limits();
        test_spare_index();
        test_random_phases();

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pidc_pkg.sv
rtl/pidc_div.sv
rtl/pidc_mac.sv
rtl/pid_controller_clamped.sv
rtl/pidc_chk.sv
test/pid_controller_clamped_tb.sv
